// ===== rtl/core/rbb_pkg.sv =====
// shared types, constants and the reciprocal table of the region box blur
`timescale 1ns / 1ps

package rbb_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int POS_W       = 6;
  localparam int DIM_REG_W   = 7;
  localparam int REGION_W    = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int COL_SUM_W   = 18;
  localparam int WIN_SUM_W   = 20;
  localparam int WIN_CNT_W   = 4;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 25;
  localparam int LINE_ROWS   = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BOTTOM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_RIGHT  = 3'd5;

  // opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // one column of the 3x3 window
  typedef struct packed {
    logic [COL_SUM_W-1:0] csum;
    logic [1:0]           cnt;
    logic [SAMPLE_W-1:0]  center;
  } col_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  typedef logic [LINE_ROWS-1:0][SAMPLE_W-1:0] line_word_t;

  // ceil(2^24 / cnt), i.e. ceil(2^25 / (2 * cnt))
  function automatic logic [RECIP_W-1:0] recip(input logic [WIN_CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    unique case (cnt)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097152;
      4'd9:    r = 25'd1864136;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/rbb_if.sv =====
// stream interfaces for pixel items and result items
`timescale 1ns / 1ps

interface rbb_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [rbb_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface rbb_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbb_pkg::SAMPLE_W-1:0] pixel_out;
  logic        [rbb_pkg::POS_W-1:0]    out_row;
  logic        [rbb_pkg::POS_W-1:0]    out_col;
  logic                                last;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output last, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input last, output ready);
endinterface

// ===== rtl/core/rbb_line_store.sv =====
// line store: four rows of samples, one lane per row, column addressed
`timescale 1ns / 1ps

module rbb_line_store #(
  parameter int MAX_DIM = 64
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [1:0]                        wr_lane_i,
  input  logic [$clog2(MAX_DIM)-1:0]        wr_addr_i,
  input  logic [rbb_pkg::SAMPLE_W-1:0]      wr_data_i,
  input  logic [$clog2(MAX_DIM)-1:0]        rd_addr_i,
  output rbb_pkg::line_word_t               rd_data_o
);

  rbb_pkg::line_word_t mem_q [MAX_DIM];
  rbb_pkg::line_word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i][wr_lane_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/core/rbb_col_cell.sv =====
// one window column cell: holds a column sum, count and center, shifts to its neighbor
`timescale 1ns / 1ps

module rbb_col_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbb_pkg::cell_ctrl_t ctrl_i,
  input  rbb_pkg::col_t       col_i,
  output rbb_pkg::col_t       col_o
);

  rbb_pkg::col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (ctrl_i.clear) begin
      col_q <= '0;
    end else if (ctrl_i.shift) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== rtl/core/region_box_blur_3x3_unit.sv =====
// top level of the region box blur: control sequencer, window chain and rounded mean
//
// Pixels of a num_rows x num_cols matrix enter on in_i in raster order (opcode pixel),
// one sample per transfer. The same matrix leaves on out_o in raster order with row,
// column and a last flag; pixels inside the region carry the rounded mean of their
// in-matrix 3x3 neighbourhood, others pass unchanged. Output lags input by one row
// and one column; after the last pixel, one flush transfer drains one pending result.
// Items that give no result leave the sequencer idle and ready. An item that gives a
// result passes the column loads, the window sum and the reciprocal multiply before it
// reaches out_o, with an extra column load at the first column of a row, and the
// next item is taken once the result enters the output register. Each load is
// one read of the line store plus one shift of the three-cell column chain. If out_o
// is stalled, the finished result waits in the multiply step until the output register
// frees. Reset sets the registers to their defaults and both positions to the matrix
// origin; the line store needs no clearing pass since only written entries are read.
// Writing num_rows or num_cols while the sequencer is idle restarts the matrix.
`timescale 1ns / 1ps

module region_box_blur_3x3_unit #(
  parameter int MAX_DIM = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  rbb_in_if.sink                             in_i,
  rbb_out_if.source                          out_o
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int PEND_W = $clog2(MAX_DIM + 3);
  localparam int SW     = rbb_pkg::SAMPLE_W;
  localparam int WSW    = rbb_pkg::WIN_SUM_W;
  localparam int PROD_W = rbb_pkg::WIN_SUM_W + rbb_pkg::RECIP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SUM,
    ST_MUL
  } state_e;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [rbb_pkg::DIM_REG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // configuration
  logic [rbb_pkg::DIM_REG_W-1:0] rows_q, cols_q;
  logic [rbb_pkg::REGION_W-1:0]  top_q, left_q, bottom_q, right_q;

  // sequencer state
  state_e            state_q;
  logic [IDX_W-1:0]  in_r_q, in_c_q, out_r_q, out_c_q;
  logic              in_done_q;
  logic [PEND_W-1:0] pend_q;
  logic [DIM_W-1:0]  load_col_q;
  logic              two_q;
  logic [WSW-1:0]    n_q;
  logic [rbb_pkg::WIN_CNT_W-1:0] cnt_q;
  logic              neg_q, blur_q;
  logic [SW-1:0]     center_q;
  logic              out_valid_q, out_last_q;
  logic [SW-1:0]     out_pix_q;
  logic [rbb_pkg::POS_W-1:0] out_row_q, out_col_q;

  logic [DIM_W-1:0]  rows_eff, cols_eff;
  logic              accept, is_pix, wr_en, emit_start, in_last, out_last, dim_wr;
  rbb_pkg::cell_ctrl_t cell_ctrl;
  rbb_pkg::col_t     chain [4];
  rbb_pkg::line_word_t rd_word;
  logic [1:0]        b_mid, b_up, b_dn;
  logic              up_ok, dn_ok, col_ok;
  logic [WSW-1:0]    win_sum, mag, n_d;
  logic [rbb_pkg::WIN_CNT_W-1:0] win_cnt;
  logic [PROD_W-1:0] prod;
  logic [WSW-1:0]    quot;
  logic [SW-1:0]     mean_val;
  logic              in_region;

  assign rows_eff = eff_dim(rows_q);
  assign cols_eff = eff_dim(cols_q);

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign is_pix     = (in_i.opcode == rbb_pkg::OP_PIXEL);
  assign wr_en      = accept && is_pix && !in_done_q;
  assign emit_start = (wr_en && (pend_q >= PEND_W'(cols_eff) + PEND_W'(1))) ||
                      (accept && !is_pix && in_done_q && (pend_q != '0));
  assign in_last    = (DIM_W'(in_r_q) == rows_eff - DIM_W'(1)) &&
                      (DIM_W'(in_c_q) == cols_eff - DIM_W'(1));
  assign out_last   = (DIM_W'(out_r_q) == rows_eff - DIM_W'(1)) &&
                      (DIM_W'(out_c_q) == cols_eff - DIM_W'(1));
  assign dim_wr     = cfg_we_i && ((cfg_idx_i == rbb_pkg::REG_NUM_ROWS) ||
                                   (cfg_idx_i == rbb_pkg::REG_NUM_COLS));

  // line store
  rbb_line_store #(
    .MAX_DIM (MAX_DIM)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_lane_i (in_r_q[1:0]),
    .wr_addr_i (in_c_q),
    .wr_data_i (in_i.sample),
    .rd_addr_i (IDX_W'(load_col_q)),
    .rd_data_o (rd_word)
  );

  // new column from the line store
  assign b_mid  = out_r_q[1:0];
  assign b_up   = b_mid - 2'd1;
  assign b_dn   = b_mid + 2'd1;
  assign up_ok  = (out_r_q != '0);
  assign dn_ok  = (DIM_W'(out_r_q) + DIM_W'(1)) < rows_eff;
  assign col_ok = (load_col_q < cols_eff);

  always_comb begin
    chain[3] = '0;
    if (col_ok) begin
      chain[3].csum = {{2{rd_word[b_mid][SW-1]}}, rd_word[b_mid]};
      if (up_ok) begin
        chain[3].csum = chain[3].csum + {{2{rd_word[b_up][SW-1]}}, rd_word[b_up]};
      end
      if (dn_ok) begin
        chain[3].csum = chain[3].csum + {{2{rd_word[b_dn][SW-1]}}, rd_word[b_dn]};
      end
      chain[3].cnt    = 2'd1 + {1'b0, up_ok} + {1'b0, dn_ok};
      chain[3].center = rd_word[b_mid];
    end
  end

  assign cell_ctrl.clear = emit_start && (out_c_q == '0);
  assign cell_ctrl.shift = (state_q == ST_LOAD);

  // window chain: cell 0 is column c-1, cell 1 column c, cell 2 column c+1
  for (genvar i = 0; i < 3; i++) begin : g_cell
    rbb_col_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .col_i  (chain[i+1]),
      .col_o  (chain[i])
    );
  end

  // window sum and rounding numerator 2*|sum| + cnt
  assign win_sum = {{2{chain[0].csum[17]}}, chain[0].csum} +
                   {{2{chain[1].csum[17]}}, chain[1].csum} +
                   {{2{chain[2].csum[17]}}, chain[2].csum};
  assign win_cnt = {2'b0, chain[0].cnt} + {2'b0, chain[1].cnt} + {2'b0, chain[2].cnt};
  assign mag     = win_sum[WSW-1] ? (~win_sum + WSW'(1)) : win_sum;
  assign n_d     = {mag[WSW-2:0], 1'b0} + WSW'(win_cnt);

  assign in_region = (32'(out_r_q) >= 32'(top_q))  && (32'(out_r_q) <= 32'(bottom_q)) &&
                     (32'(out_c_q) >= 32'(left_q)) && (32'(out_c_q) <= 32'(right_q));

  // division by 2*cnt through the reciprocal table
  assign prod     = PROD_W'(n_q) * PROD_W'(rbb_pkg::recip(cnt_q));
  assign quot     = prod[rbb_pkg::RECIP_SHIFT +: WSW];
  assign mean_val = neg_q ? (~quot[SW-1:0] + SW'(1)) : quot[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= 7'd64;
      cols_q   <= 7'd64;
      top_q    <= 6'd0;
      left_q   <= 6'd0;
      bottom_q <= 6'd63;
      right_q  <= 6'd63;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbb_pkg::REG_NUM_ROWS:      rows_q   <= cfg_wdata_i;
        rbb_pkg::REG_NUM_COLS:      cols_q   <= cfg_wdata_i;
        rbb_pkg::REG_REGION_TOP:    top_q    <= cfg_wdata_i[rbb_pkg::REGION_W-1:0];
        rbb_pkg::REG_REGION_LEFT:   left_q   <= cfg_wdata_i[rbb_pkg::REGION_W-1:0];
        rbb_pkg::REG_REGION_BOTTOM: bottom_q <= cfg_wdata_i[rbb_pkg::REGION_W-1:0];
        rbb_pkg::REG_REGION_RIGHT:  right_q  <= cfg_wdata_i[rbb_pkg::REGION_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_r_q      <= '0;
      in_c_q      <= '0;
      out_r_q     <= '0;
      out_c_q     <= '0;
      in_done_q   <= 1'b0;
      pend_q      <= '0;
      load_col_q  <= '0;
      two_q       <= 1'b0;
      n_q         <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      blur_q      <= 1'b0;
      center_q    <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_pix_q   <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
    end else begin
      if (out_o.ready && (state_q != ST_MUL)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (dim_wr) begin
            in_r_q    <= '0;
            in_c_q    <= '0;
            out_r_q   <= '0;
            out_c_q   <= '0;
            in_done_q <= 1'b0;
            pend_q    <= '0;
          end else begin
            if (wr_en) begin
              pend_q <= pend_q + PEND_W'(1);
              if (in_last) begin
                in_done_q <= 1'b1;
              end
              if (DIM_W'(in_c_q) == cols_eff - DIM_W'(1)) begin
                in_c_q <= '0;
                in_r_q <= in_r_q + IDX_W'(1);
              end else begin
                in_c_q <= in_c_q + IDX_W'(1);
              end
            end
            if (emit_start) begin
              state_q <= ST_READ;
              if (out_c_q == '0) begin
                load_col_q <= '0;
                two_q      <= 1'b1;
              end else begin
                load_col_q <= DIM_W'(out_c_q) + DIM_W'(1);
                two_q      <= 1'b0;
              end
            end
          end
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          if (two_q) begin
            two_q      <= 1'b0;
            load_col_q <= DIM_W'(1);
            state_q    <= ST_READ;
          end else begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          n_q      <= n_d;
          cnt_q    <= win_cnt;
          neg_q    <= win_sum[WSW-1];
          blur_q   <= in_region;
          center_q <= chain[1].center;
          state_q  <= ST_MUL;
        end
        ST_MUL: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= blur_q ? mean_val : center_q;
            out_row_q   <= rbb_pkg::POS_W'(out_r_q);
            out_col_q   <= rbb_pkg::POS_W'(out_c_q);
            out_last_q  <= out_last;
            state_q     <= ST_IDLE;
            if (out_last) begin
              in_r_q    <= '0;
              in_c_q    <= '0;
              out_r_q   <= '0;
              out_c_q   <= '0;
              in_done_q <= 1'b0;
              pend_q    <= '0;
            end else begin
              pend_q <= pend_q - PEND_W'(1);
              if (DIM_W'(out_c_q) == cols_eff - DIM_W'(1)) begin
                out_c_q <= '0;
                out_r_q <= out_r_q + IDX_W'(1);
              end else begin
                out_c_q <= out_c_q + IDX_W'(1);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_out = out_pix_q;
  assign out_o.out_row   = out_row_q;
  assign out_o.out_col   = out_col_q;
  assign out_o.last      = out_last_q;

endmodule
